// ===== sv/ets_pkg.sv =====
package ets_pkg;

  localparam int W_WIDTH = 32;
  localparam int DIST_WIDTH = 37;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic CFG_VCOUNT   = 1'b0;
  localparam logic CFG_DIRECTED = 1'b1;

  localparam int TOUR_ORIGIN = 0;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CLEAR = 10'b0000000010,
    ST_EDGE2 = 10'b0000000100,
    ST_SINIT = 10'b0000001000,
    ST_SCAN  = 10'b0000010000,
    ST_CLOSE = 10'b0000100000,
    ST_BACK  = 10'b0001000000,
    ST_ENTER = 10'b0010000000,
    ST_EMIT  = 10'b0100000000,
    ST_WAIT  = 10'b1000000000
  } state_t;

endpackage

// ===== sv/exhaustive_tour_search_core.sv =====
// Channel | Direction | tdata (low bit up)                          | tuser | tlast
// in_     | slave     | req_type, from_vertex, to_vertex, edge_weight | -     | -
// out_    | master    | tour_vertex, tour_distance                  | found | last_of_tour
// cfg_    | write     | index 0 vertex_count, 1 directed_graph      | -     | -
// An undirected edge is also written in reverse; a clear sweeps every store word,
// one per cycle, after the accepting cycle.
// A search reads the adjacency store through a single read port: each neighbor test
// waits for its registered read, entering a vertex reads its closing edge first and
// backing out reads the edge it came in on; the results follow once the search is done.
// Reset clears the adjacency store with the same sweep; no request is
// taken meanwhile. A stalled result holds the block in its emit state.
module exhaustive_tour_search_core
  import ets_pkg::*;
#(
  parameter int MAX_VERTICES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // req_type, from_vertex, to_vertex, edge_weight
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // tour_vertex, tour_distance
  output logic        out_tuser,  // tour_found
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wr_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int AW = 2 * VW;
  localparam int CW = VW + 1;
  localparam int DEPTH = 1 << AW;
  localparam logic [CW-1:0] MAXV = CW'(MAX_VERTICES);

  state_t state_r, state_nxt;

  logic [3:0] vcount_r;
  logic       directed_r;
  logic [CW-1:0] n_act;

  logic [VW-1:0] path_r [MAX_VERTICES];
  logic [CW-1:0] nxt_r  [MAX_VERTICES];
  logic [VW-1:0] best_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited_r;
  logic [DIST_WIDTH-1:0] cur_len_r, best_len_r;
  logic found_r;
  logic [VW-1:0] depth_r;
  logic [CW-1:0] cand_r;
  logic [CW-1:0] k_r;
  logic [AW-1:0] clr_r;
  logic          rd_pend_r, rd_pend_nxt;
  logic [VW-1:0] ev_r, et_r;
  logic [W_WIDTH-1:0] ew_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [W_WIDTH-1:0] wr_data, rd_data;

  logic [1:0] in_req;
  logic [2:0] in_from, in_to;
  logic [W_WIDTH-1:0] in_w;
  assign in_req  = in_tdata[1:0];
  assign in_from = in_tdata[4:2];
  assign in_to   = in_tdata[7:5];
  assign in_w    = in_tdata[39:8];

  ets_ram #(.WIDTH(W_WIDTH), .DEPTH(DEPTH)) u_adj (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_comb begin
    if (vcount_r == 4'd0) n_act = CW'(1);
    else if ({1'b0, vcount_r} > 5'(MAX_VERTICES)) n_act = MAXV;
    else n_act = CW'(vcount_r);
  end

  logic in_range;
  assign in_range = (32'(in_from) < 32'(MAX_VERTICES)) && (32'(in_to) < 32'(MAX_VERTICES));

  logic [VW-1:0] cur_v, prev_v;
  logic [VW-1:0] cand_v;
  logic last_depth;
  assign cur_v = path_r[depth_r];
  assign prev_v = (depth_r == '0) ? '0 : path_r[depth_r - VW'(1)];
  assign cand_v = cand_r[VW-1:0];
  assign last_depth = (CW'(depth_r) == n_act - CW'(1));

  logic [DIST_WIDTH-1:0] sum;
  assign sum = cur_len_r + DIST_WIDTH'(rd_data);

  // Read address follows the state: scan reads cur->cand, enter and close read cur->0,
  // backtrack reads prev->cur.
  always_comb begin
    rd_addr = {cur_v, cand_v};
    if (state_r == ST_CLOSE || state_r == ST_ENTER) rd_addr = {cur_v, VW'(TOUR_ORIGIN)};
    else if (state_r == ST_BACK) rd_addr = {prev_v, cur_v};
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = {ev_r, et_r};
    wr_data = ew_r;
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1; wr_addr = clr_r; wr_data = '0;
    end else if (state_r == ST_EDGE2) begin
      wr_en = 1'b1; wr_addr = {et_r, ev_r};
    end else if (state_r == ST_IDLE && in_tvalid && in_req == REQ_ADD && in_range) begin
      wr_en = 1'b1; wr_addr = {VW'(in_from), VW'(in_to)}; wr_data = in_w;
    end
  end

  // A read is pending in the cycle after its address was presented.
  always_comb begin
    rd_pend_nxt = 1'b0;
    if (state_r == ST_ENTER) rd_pend_nxt = 1'b1;
    else if (state_r == ST_SCAN) rd_pend_nxt = (cand_r < n_act) && !rd_pend_r;
    else if (state_r == ST_BACK) rd_pend_nxt = !rd_pend_r;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);

  logic [VW-1:0] emit_v;
  always_comb begin
    emit_v = '0;
    if (found_r && k_r < n_act) emit_v = best_r[k_r[VW-1:0]];
  end
  assign out_tdata = {(found_r ? best_len_r : DIST_WIDTH'(0)), 3'(emit_v)};
  assign out_tuser = found_r;
  assign out_tlast = !found_r || (k_r == n_act);

  logic acc_in;
  assign acc_in = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc_in) begin
        case (in_req)
          REQ_ADD:    if (in_range && !directed_r) state_nxt = ST_EDGE2;
          REQ_SEARCH: state_nxt = ST_SINIT;
          REQ_CLEAR:  state_nxt = ST_CLEAR;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_EDGE2: state_nxt = ST_IDLE;
      ST_SINIT: state_nxt = ST_ENTER;
      ST_ENTER: state_nxt = rd_pend_r ? ST_CLOSE : ST_ENTER;
      ST_CLOSE: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (cand_r >= n_act) state_nxt = (depth_r == '0) ? ST_EMIT : ST_BACK;
        else if (rd_pend_r && rd_data != '0 && !visited_r[cand_v]) state_nxt = ST_ENTER;
      end
      ST_BACK: if (rd_pend_r) state_nxt = ST_SCAN;
      ST_EMIT: if (out_tready && out_tlast) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      vcount_r <= 4'd8;
      directed_r <= 1'b0;
      rd_pend_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == CFG_VCOUNT) vcount_r <= cfg_wr_data;
        else directed_r <= cfg_wr_data[0];
      end
      rd_pend_r <= rd_pend_nxt;
      case (state_r)
        ST_IDLE: begin
          clr_r <= '0;
          ev_r <= VW'(in_from);
          et_r <= VW'(in_to);
          ew_r <= in_w;
        end
        ST_CLEAR: clr_r <= clr_r + AW'(1);
        ST_SINIT: begin
          depth_r <= '0;
          path_r[0] <= VW'(TOUR_ORIGIN);
          visited_r <= MAX_VERTICES'(1);
          cur_len_r <= '0;
          best_len_r <= '0;
          found_r <= 1'b0;
          k_r <= '0;
        end
        ST_CLOSE: begin
          // rd_data is the closing edge back to the start vertex.
          cand_r <= '0;
          if (last_depth && rd_data != '0 && (!found_r || sum < best_len_r)) begin
            best_r <= path_r;
            best_len_r <= sum;
            found_r <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (cand_r < n_act && rd_pend_r) begin
            if (rd_data != '0 && !visited_r[cand_v]) begin
              nxt_r[depth_r] <= cand_r + CW'(1);
              cur_len_r <= sum;
              depth_r <= depth_r + VW'(1);
              path_r[depth_r + VW'(1)] <= cand_v;
              visited_r[cand_v] <= 1'b1;
            end else cand_r <= cand_r + CW'(1);
          end
        end
        ST_BACK: begin
          if (rd_pend_r) begin
            visited_r[cur_v] <= 1'b0;
            cur_len_r <= cur_len_r - DIST_WIDTH'(rd_data);
            depth_r <= depth_r - VW'(1);
            cand_r <= nxt_r[depth_r - VW'(1)];
          end
        end
        ST_EMIT: if (out_tready) k_r <= k_r + CW'(1);
        default: ;
      endcase
    end
  end

  property p_no_accept_emit;
    @(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid);
  endproperty
  assert property (p_no_accept_emit) else $error("accept while emitting");

  property p_origin_on_path;
    @(posedge clk) disable iff (!rst_n)
      visited_r[TOUR_ORIGIN] || state_r == ST_IDLE || state_r == ST_CLEAR
      || state_r == ST_EDGE2 || state_r == ST_SINIT;
  endproperty
  assert property (p_origin_on_path) else $error("start vertex left the path");

  property p_emit_hold;
    @(posedge clk) disable iff (!rst_n) out_tvalid && !out_tready |=> out_tvalid;
  endproperty
  assert property (p_emit_hold) else $error("result dropped");

  property p_wr_idle_search;
    @(posedge clk) disable iff (!rst_n) (state_r == ST_SCAN) |-> !wr_en;
  endproperty
  assert property (p_wr_idle_search) else $error("store written during search");

endmodule

// ===== sv/ets_ram.sv =====
module ets_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb
  import ets_pkg::*;
();

  localparam int NV = 8;

  typedef struct packed {
    logic [2:0]  vertex;
    logic [36:0] distance;
    logic        found;
    logic        last;
  } tour_step_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // req_type, from_vertex, to_vertex, edge_weight
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // tour_vertex, tour_distance
  logic        out_tuser;   // tour_found
  logic        out_tlast;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [3:0]  cfg_wr_data;

  exhaustive_tour_search_core #(.MAX_VERTICES(NV)) DUT (.*);

  // Shadow of the block's graph store and registers.
  logic [31:0] edge_w [NV][NV];
  logic [3:0]  vcount_reg;
  logic        directed_reg;

  tour_step_t  tour_q[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          errors;
  int          results_seen;
  int          searches_sent;
  int          items_sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #200_000_000;
    $display("Timeout waiting for the block");
    $display("Regression FAIL");
    $finish;
  end

  // Depth-first walk over all tours from vertex 0, queueing the emitted results.
  function automatic void predict_search();
    int          n, d, v, i, k;
    logic [7:0]  seen;
    logic [2:0]  path [NV];
    int          nxt [NV];
    logic [2:0]  best_tour [NV];
    logic [36:0] len, best, total;
    bit          have;
    tour_step_t  r;
    n = (vcount_reg < 1) ? 1 : (vcount_reg > NV) ? NV : vcount_reg;
    seen = 8'd1;
    path[0] = 3'(TOUR_ORIGIN);
    nxt[0] = 0;
    len = '0;
    best = '0;
    have = 0;
    d = 0;
    if (n == 1 && edge_w[0][TOUR_ORIGIN] != 0) begin
      best_tour[0] = 3'(TOUR_ORIGIN);
      best = 37'(edge_w[0][TOUR_ORIGIN]);
      have = 1;
    end
    while (1) begin
      v = path[d];
      i = nxt[d];
      while (i < n && (edge_w[v][i] == 0 || seen[i])) i++;
      if (i < n) begin
        nxt[d] = i + 1;
        len = len + 37'(edge_w[v][i]);
        d++;
        seen[i] = 1'b1;
        path[d] = 3'(i);
        nxt[d] = 0;
        if (d == n - 1 && edge_w[i][TOUR_ORIGIN] != 0) begin
          total = len + 37'(edge_w[i][TOUR_ORIGIN]);
          if (!have || total < best) begin
            for (k = 0; k < NV; k++) best_tour[k] = path[k];
            best = total;
            have = 1;
          end
        end
      end else begin
        if (d == 0) break;
        seen[v] = 1'b0;
        len = len - 37'(edge_w[path[d-1]][v]);
        d--;
      end
    end
    if (!have) begin
      r = '{vertex: 3'd0, distance: '0, found: 1'b0, last: 1'b1};
      tour_q.push_back(r);
    end else begin
      for (k = 0; k <= n; k++) begin
        r.vertex = (k < n) ? best_tour[k] : 3'(TOUR_ORIGIN);
        r.distance = best;
        r.found = 1'b1;
        r.last = (k == n);
        tour_q.push_back(r);
      end
    end
  endfunction

  function automatic void apply_request(logic [1:0] req, logic [2:0] src, logic [2:0] dst,
                                        logic [31:0] w);
    case (req)
      REQ_ADD: begin
        edge_w[src][dst] = w;
        if (!directed_reg) edge_w[dst][src] = w;
      end
      REQ_CLEAR: begin
        foreach (edge_w[a, b]) edge_w[a][b] = '0;
      end
      REQ_SEARCH: begin
        searches_sent++;
        predict_search();
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [1:0] req, logic [2:0] src, logic [2:0] dst,
                              logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {w, dst, src, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(req, src, dst, w);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Lets the last results drain and any clear sweep finish before a register write.
  task automatic wait_quiet();
    @(negedge clk);
    while (tour_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    wait_quiet();
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wr_data = val;
    if (idx == CFG_VCOUNT) vcount_reg = val;
    else directed_reg = val[0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    tour_step_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = '{vertex: out_tdata[2:0], distance: out_tdata[39:3], found: out_tuser,
              last: out_tlast};
      if (tour_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %p", got);
      end else begin
        want = tour_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic test_small_graphs();
    send_request(REQ_SEARCH, 3'd0, 3'd0, 32'd0);
    write_reg(CFG_VCOUNT, 4'd1);
    send_request(REQ_SEARCH, 3'd0, 3'd0, 32'd0);
    send_request(REQ_ADD, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send_request(REQ_SEARCH, 3'd0, 3'd0, 32'd0);
    write_reg(CFG_VCOUNT, 4'd0);
    send_request(REQ_SEARCH, 3'd0, 3'd0, 32'd0);
  endtask

  task automatic test_undirected_square();
    write_reg(CFG_VCOUNT, 4'd4);
    send_request(REQ_ADD, 3'd0, 3'd1, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 3'd1, 3'd2, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 3'd2, 3'd3, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 3'd3, 3'd0, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 3'd7, 3'd6, 32'd9);
    send_request(REQ_ADD, 3'd0, 3'd2, 32'd5);
    send_request(REQ_ADD, 3'd0, 3'd2, 32'd0);
    send_request(REQ_NONE, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_request(REQ_SEARCH, 3'd0, 3'd0, 32'd0);
    send_request(REQ_CLEAR, 3'd0, 3'd0, 32'd0);
    send_request(REQ_SEARCH, 3'd0, 3'd0, 32'd0);
  endtask

  // Full-size directed ring with two shortcuts; the vertex count saturates at the maximum.
  task automatic test_directed_ring();
    write_reg(CFG_DIRECTED, 4'd1);
    write_reg(CFG_VCOUNT, 4'd15);
    for (int v = 0; v < NV; v++) send_request(REQ_ADD, 3'(v), 3'((v + 1) % NV), 32'(v + 1));
    send_request(REQ_ADD, 3'd2, 3'd4, 32'd1);
    send_request(REQ_ADD, 3'd4, 3'd3, 32'd1);
    send_request(REQ_SEARCH, 3'd0, 3'd0, 32'd0);
  endtask

  function automatic logic [31:0] pick_weight();
    return ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 20);
  endfunction

  task automatic test_random_graphs(int idle_pct, int stall_pct);
    int n, start;
    wait_quiet();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < 15) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(2, 6);
      write_reg(CFG_VCOUNT, 4'(n));
      write_reg(CFG_DIRECTED, 4'($urandom_range(1)));
      if ($urandom_range(1)) send_request(REQ_CLEAR, 3'($urandom), 3'($urandom), $urandom);
      for (int e = 0; e < n + $urandom_range(n); e++)
        send_request(REQ_ADD, 3'($urandom_range(n > 0 ? n - 1 : 0)),
                     3'($urandom_range(n > 0 ? n - 1 : 0)), pick_weight());
      case ($urandom_range(4))
        0: send_request(REQ_NONE, 3'($urandom), 3'($urandom), $urandom);
        1: send_request(REQ_ADD, 3'($urandom), 3'($urandom),
                        $urandom_range(1) ? 32'd0 : $urandom);
        default: ;
      endcase
      send_request(REQ_SEARCH, 3'($urandom), 3'($urandom), $urandom);
    end
  endtask

  initial begin
    foreach (edge_w[a, b]) edge_w[a][b] = '0;
    vcount_reg = 4'd8;
    directed_reg = 1'b0;
    errors = 0;
    results_seen = 0;
    searches_sent = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_VCOUNT;
    cfg_wr_data = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    repeat (100) @(negedge clk);

    test_small_graphs();
    test_undirected_square();
    test_directed_ring();
    test_random_graphs(0, 0);
    test_random_graphs(81, 0);
    test_random_graphs(0, 81);
    test_random_graphs(37, 37);

    wait_quiet();
    $display("Sent %0d requests including %0d tour searches; checked %0d results.",
             items_sent, searches_sent, results_seen);
    $display("Errors: %0d", errors);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
